// ===== design/swst_pkg.sv =====
`timescale 1ns / 1ps

package swst_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W = 7;
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int MAX_WINDOW_DEF = 64;
  localparam logic [CNT_W-1:0] WINDOW_RESET = 7'd64;

  function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] raw,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] len;
    len = raw;
    if (raw == '0) begin
      len = 7'd1;
    end else if (raw > cap) begin
      len = cap;
    end
    return len;
  endfunction

endpackage

// ===== design/swst_ring.sv =====
`timescale 1ns / 1ps

module swst_ring #(
  parameter int DEPTH = swst_pkg::MAX_WINDOW_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [swst_pkg::SAMPLE_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [swst_pkg::SAMPLE_W-1:0] rdata
);
  import swst_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/swst_div.sv =====
`timescale 1ns / 1ps

module swst_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [swst_pkg::SUM_W-1:0]    dividend,
  input  logic [swst_pkg::CNT_W-1:0]           divisor,
  output logic                                 done,
  output logic signed [swst_pkg::SAMPLE_W-1:0] quotient
);
  import swst_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic [SUM_W-1:0]  dq;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;
  logic [SAMPLE_W-1:0] mag;

  always_comb begin
    rem_sh = {rem, dq[SUM_W-1]};
    ge = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
    mag = dq[SAMPLE_W-1:0];
    quotient = neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg <= dividend[SUM_W-1];
        dq <= dividend[SUM_W-1] ? -dividend : dividend;
        rem <= '0;
      end else if (busy) begin
        rem <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dq <= {dq[SUM_W-2:0], ge};
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/sliding_window_stats_core.sv =====
`timescale 1ns / 1ps

// Keeps the last window_length signed Q8.8 samples and, for each sample taken,
// returns that sample with the mean, minimum and maximum of the held samples and
// their count. After a request is accepted, the held samples are read one per
// cycle through the single read port of the sample memory, then the mean comes
// from a divider that resolves one quotient bit per cycle over 23 steps. Input
// is taken again once the result is in the output register. Writing a window
// length whose effective value differs from the current one empties the window;
// the configuration port is always ready and must only be written while idle.
module sliding_window_stats_core #(
  parameter int MAX_WINDOW = swst_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swst_pkg::CNT_W-1:0]           window_length,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swst_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swst_pkg::SAMPLE_W-1:0] newest,
  output logic signed [swst_pkg::SAMPLE_W-1:0] mean,
  output logic signed [swst_pkg::SAMPLE_W-1:0] minimum,
  output logic signed [swst_pkg::SAMPLE_W-1:0] maximum,
  output logic [swst_pkg::CNT_W-1:0]           fill
);
  import swst_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int LEN_CAP_INT = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
  localparam logic [CNT_W-1:0] LEN_CAP = CNT_W'(LEN_CAP_INT);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DIVIDE,
    DONE
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           win_raw;
  logic [CNT_W-1:0]           len_cur;
  logic [AW-1:0]              write_pos;
  logic [CNT_W-1:0]           held_count;
  logic [AW-1:0]              idx;
  logic                       issuing;
  logic                       rd_vld;
  logic                       first;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;
  logic signed [SAMPLE_W-1:0] newest_r;
  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_q;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] q;
  logic                       accept;
  logic                       re;

  assign len_cur = eff_len(win_raw, LEN_CAP);
  assign cfg_ready = 1'b1;
  assign in_ready = (state == IDLE);
  assign accept = in_valid && in_ready;
  assign re = (state == SCAN) && issuing;
  assign q = $signed(rdata);

  swst_ring #(
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk(clk),
    .we(accept),
    .waddr(write_pos),
    .wdata(sample),
    .re(re),
    .raddr(idx),
    .rdata(rdata)
  );

  swst_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(sum),
    .divisor(held_count),
    .done(div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      win_raw <= WINDOW_RESET;
      write_pos <= '0;
      held_count <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      issuing <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        win_raw <= window_length;
        if (eff_len(window_length, LEN_CAP) != len_cur) begin
          write_pos <= '0;
          held_count <= '0;
        end
      end
      case (state)
        IDLE: begin
          if (accept) begin
            newest_r <= sample;
            if (int'(write_pos) + 1 == int'(len_cur)) begin
              write_pos <= '0;
            end else begin
              write_pos <= write_pos + 1'b1;
            end
            if (held_count < len_cur) begin
              held_count <= held_count + 1'b1;
            end
            idx <= '0;
            issuing <= 1'b1;
            rd_vld <= 1'b0;
            first <= 1'b1;
            state <= SCAN;
          end
        end
        SCAN: begin
          rd_vld <= issuing;
          if (issuing) begin
            if (int'(idx) + 1 == int'(held_count)) begin
              issuing <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          if (rd_vld) begin
            first <= 1'b0;
            if (first) begin
              sum <= SUM_W'(q);
              lo <= q;
              hi <= q;
            end else begin
              sum <= sum + SUM_W'(q);
              if (q < lo) begin
                lo <= q;
              end
              if (q > hi) begin
                hi <= q;
              end
            end
          end
          if (!issuing && !rd_vld) begin
            div_start <= 1'b1;
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            newest <= newest_r;
            mean <= div_q;
            minimum <= lo;
            maximum <= hi;
            fill <= held_count;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) held_count <= len_cur)
    else $error("held count exceeds window length");

  assert property (@(posedge clk) disable iff (rst) int'(write_pos) < int'(len_cur))
    else $error("write position outside window");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (fill != '0) && (minimum <= maximum))
    else $error("result with empty window or minimum above maximum");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (mean >= minimum) && (mean <= maximum))
    else $error("mean outside minimum and maximum");

  assert property (@(posedge clk) disable iff (rst) accept |=> state == SCAN && held_count != '0)
    else $error("accepted request did not start a scan");

endmodule

// ===== tb/sv/sliding_window_stats_core_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_stats_core_tb;

  import swst_pkg::*;

  localparam int WINDOW_CAP = MAX_WINDOW_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] newest;
    logic signed [SAMPLE_W-1:0] mean;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic [CNT_W-1:0]           fill;
  } window_stats_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CNT_W-1:0]           window_length = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] newest;
  logic signed [SAMPLE_W-1:0] mean;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [SAMPLE_W-1:0] maximum;
  logic [CNT_W-1:0]           fill;

  logic signed [SAMPLE_W-1:0] held_samples [WINDOW_CAP];
  int                         next_slot = 0;
  int                         held_total = 0;
  logic [CNT_W-1:0]           window_cfg = WINDOW_RESET;
  window_stats_t              expected_stats [$];

  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int windows_written = 0;
  int mismatches = 0;
  int cycle_count = 0;

  sliding_window_stats_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .window_length(window_length),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .newest(newest),
    .mean(mean),
    .minimum(minimum),
    .maximum(maximum),
    .fill(fill)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               expected_stats.size());
      $display("FAIL sliding_window_stats_core");
      $finish;
    end
  end

  function automatic int clamp_window(input logic [CNT_W-1:0] raw);
    int len;
    len = int'(raw);
    if (len == 0) begin
      len = 1;
    end else if (len > WINDOW_CAP) begin
      len = WINDOW_CAP;
    end
    return len;
  endfunction

  function automatic window_stats_t stats_after(input logic signed [SAMPLE_W-1:0] s);
    int len;
    int first;
    int acc;
    int lo;
    int hi;
    int v;
    int i;
    window_stats_t r;
    len = clamp_window(window_cfg);
    if (next_slot >= len) begin
      next_slot = 0;
    end
    if (held_total > len) begin
      held_total = len;
    end
    held_samples[next_slot] = s;
    next_slot = (next_slot + 1) % len;
    if (held_total < len) begin
      held_total++;
    end
    first = (next_slot + len - held_total) % len;
    acc = 0;
    lo = 0;
    hi = 0;
    for (i = 0; i < held_total; i++) begin
      v = int'(held_samples[(first + i) % len]);
      acc += v;
      if (i == 0 || v < lo) begin
        lo = v;
      end
      if (i == 0 || v > hi) begin
        hi = v;
      end
    end
    r.newest = s;
    r.mean = SAMPLE_W'(acc / held_total);
    r.minimum = SAMPLE_W'(lo);
    r.maximum = SAMPLE_W'(hi);
    r.fill = CNT_W'(held_total);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_W'($urandom_range(16) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic report_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  task automatic check_result();
    window_stats_t exp_r;
    if (expected_stats.size() == 0) begin
      $display("%0t: result with no request pending, expected none, got newest %0d", $time,
               newest);
      mismatches++;
    end else begin
      exp_r = expected_stats.pop_front();
      report_field("newest", exp_r.newest, newest);
      report_field("mean", exp_r.mean, mean);
      report_field("minimum", exp_r.minimum, minimum);
      report_field("maximum", exp_r.maximum, maximum);
      report_field("fill", exp_r.fill, fill);
      results_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        check_result();
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    expected_stats.push_back(stats_after(s));
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic write_window(input logic [CNT_W-1:0] raw);
    drain();
    cfg_valid <= 1'b1;
    window_length <= raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (clamp_window(raw) != clamp_window(window_cfg)) begin
      next_slot = 0;
      held_total = 0;
    end
    window_cfg = raw;
    windows_written++;
    @(posedge clk);
  endtask

  task automatic test_extremes();
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
  endtask

  task automatic test_window_changes();
    write_window(7'd2);
    send_sample(-16'sd3);
    send_sample(16'sd0);
    send_sample(16'sd5);
    send_sample(16'sh8000);
    write_window(7'd0);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    write_window(7'd1);
    send_sample(16'sd7);
    write_window(7'd127);
    send_sample(16'sd1);
    write_window(7'd100);
    send_sample(16'sd2);
    write_window(7'd64);
    send_sample(-16'sd5);
  endtask

  task automatic test_random_traffic(input int item_count);
    logic [CNT_W-1:0] raw;
    int n;
    int sent;
    sent = 0;
    while (sent < item_count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: raw = CNT_W'($urandom_range(8, 1));
        5: raw = CNT_W'($urandom_range(127));
        6: raw = window_cfg;
        7: raw = CNT_W'($urandom_range(127, 64));
        default: raw = CNT_W'($urandom_range(63, 9));
      endcase
      write_window(raw);
      n = $urandom_range(2 * clamp_window(raw) + 3, 1);
      if (n > item_count - sent) begin
        n = item_count - sent;
      end
      repeat (n) begin
        send_sample(pick_sample());
      end
      sent += n;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle_pct = 25;
    recv_idle_pct = 75;
    test_extremes();
    test_window_changes();
    test_random_traffic(260);
    sender_idle_pct = 75;
    recv_idle_pct = 25;
    test_random_traffic(260);
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(260);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d samples over %0d window settings in %0d cycles.", samples_sent,
             windows_written, cycle_count);
    $display("%0d results checked, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("PASS sliding_window_stats_core");
    end else begin
      $display("FAIL sliding_window_stats_core");
    end
    $finish;
  end

endmodule
